[src/assert_macros.svh]
// assertion macros used by the canonicalizer core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression must hold at every clock edge outside reset
`define HC_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define HC_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HC_ASSERT_ALWAYS(lbl, expr, msg)
`define HC_ASSERT_IMPLY(lbl, ante, cons, msg)
`define HC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[src/hcanon_pkg.sv]
// widths, character codes, register map and helpers of the hostname canonicalizer
package hcanon_pkg;

    localparam int BYTE_W  = 8;
    localparam int NAME_W  = 9;
    localparam int LABEL_W = 8;
    localparam int CFG_W   = 8;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [NAME_W-1:0]  t_name_cnt;
    typedef logic [LABEL_W-1:0] t_label_cnt;
    typedef logic [CFG_W-1:0]   t_cfg;

    // register map, index taken from paddr[2]
    localparam logic REG_MAX_NAME  = 1'b0;
    localparam logic REG_MAX_LABEL = 1'b1;

    // reset values of the length limits
    localparam t_cfg MAX_NAME_RST  = t_cfg'(253);
    localparam t_cfg MAX_LABEL_RST = t_cfg'(63);

    // saturation points of the counters
    localparam t_name_cnt  NAME_SAT  = '1;
    localparam t_label_cnt LABEL_SAT = '1;

    // character codes
    localparam t_byte CH_UPPER_A = 8'h41;
    localparam t_byte CH_UPPER_Z = 8'h5A;
    localparam t_byte CH_LOWER_A = 8'h61;
    localparam t_byte CH_LOWER_Z = 8'h7A;
    localparam t_byte CH_ZERO    = 8'h30;
    localparam t_byte CH_NINE    = 8'h39;
    localparam t_byte CH_HYPHEN  = 8'h2D;
    localparam t_byte CH_DOT     = 8'h2E;
    localparam t_byte CASE_OFS   = 8'h20;

    // ascii upper case to lower case, other bytes unchanged
    function automatic t_byte to_lower(input t_byte b);
        t_byte r;
        r = b;
        if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
            r = b + CASE_OFS;
        end
        return r;
    endfunction

    // letters, digits, hyphen and dot on an already lowered byte
    function automatic logic is_ldh(input t_byte b);
        return (b >= CH_ZERO && b <= CH_NINE) || (b >= CH_LOWER_A && b <= CH_LOWER_Z) ||
               (b == CH_HYPHEN) || (b == CH_DOT);
    endfunction

endpackage

[src/hcanon_ifs.sv]
// stream interfaces of the hostname canonicalizer

// raw hostname bytes
interface hcanon_in_if;
    import hcanon_pkg::*;

    logic  valid;
    logic  ready;
    t_byte name_byte;
    logic  final_byte;

    modport source (output valid, output name_byte, output final_byte, input ready);
    modport sink   (input valid, input name_byte, input final_byte, output ready);
endinterface

// lowered bytes with verdict
interface hcanon_out_if;
    import hcanon_pkg::*;

    logic  valid;
    logic  ready;
    t_byte lowered_byte;
    logic  keep_byte;
    logic  name_done;
    logic  verdict;

    modport source (output valid, output lowered_byte, output keep_byte, output name_done,
                    output verdict, input ready);
    modport sink   (input valid, input lowered_byte, input keep_byte, input name_done,
                    input verdict, output ready);
endinterface

[src/hostname_canonicalizer_core.sv]
// hostname canonicalizer top level: byte checks, counters, result register, apb registers
//
// channel    | modport  | moves
// -----------+----------+---------------------------------------------
// i_name_ch  | sink     | one raw hostname byte plus last-byte flag
// o_res_ch   | source   | lowered byte, keep flag, done flag, verdict
// apb        | slave    | max_name_length (0x0), max_label_length (0x4)
//
// one byte per cycle while the result side drains; the result appears in the cycle after its transaction is accepted
// the result register decouples the sides: a byte is taken whenever the register is
// empty or is drained in the same cycle
// reset clears counters, error flag and output valid and loads limits 253 and 63
// a stall on the result side holds the result and blocks only further input
`include "assert_macros.svh"

module hostname_canonicalizer_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    hcanon_in_if.sink                    i_name_ch,
    hcanon_out_if.source                 o_res_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hcanon_pkg::APB_AW-1:0] paddr,
    input  logic [hcanon_pkg::APB_DW-1:0] pwdata,
    output logic [hcanon_pkg::APB_DW-1:0] prdata,
    output logic                         pready
);
    import hcanon_pkg::*;

    t_cfg       r_max_name;
    t_cfg       r_max_label;
    t_name_cnt  r_name_count,  n_name_count;
    t_label_cnt r_label_count, n_label_count;
    logic       r_error_seen,  n_error_seen;

    logic       r_out_valid;
    t_byte      r_lowered;
    logic       r_keep;
    logic       r_done;
    logic       r_verdict;

    logic       in_take;
    logic       cfg_wr;
    t_byte      low;
    logic       is_dot;
    logic       root;
    logic       name_err;
    logic       label_err;
    logic       err_all;
    logic       n_keep;
    logic       n_verdict;

    // apb register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_name  <= MAX_NAME_RST;
            r_max_label <= MAX_LABEL_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_MAX_NAME:  r_max_name  <= pwdata[CFG_W-1:0];
                REG_MAX_LABEL: r_max_label <= pwdata[CFG_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MAX_NAME:  prdata = APB_DW'(r_max_name);
            REG_MAX_LABEL: prdata = APB_DW'(r_max_label);
            default:       prdata = '0;
        endcase
    end

    // input handshake
    assign i_name_ch.ready = !r_out_valid || o_res_ch.ready;
    assign in_take         = i_name_ch.valid && i_name_ch.ready;

    // byte classification and counter update
    always_comb begin
        low    = to_lower(i_name_ch.name_byte);
        is_dot = (low == CH_DOT);
        root   = i_name_ch.final_byte && (r_name_count == '0) && is_dot;

        n_name_count = (r_name_count != NAME_SAT) ? r_name_count + 1'b1 : r_name_count;
        name_err     = n_name_count > NAME_W'(r_max_name);

        if (is_dot) begin
            n_label_count = '0;
            label_err     = (r_label_count == '0);
        end else begin
            n_label_count = (r_label_count != LABEL_SAT) ? r_label_count + 1'b1
                                                         : r_label_count;
            label_err     = n_label_count > r_max_label;
        end

        err_all      = r_error_seen || name_err || label_err || !is_ldh(low);
        n_error_seen = err_all;
        n_keep       = !(i_name_ch.final_byte && is_dot && !root);
        n_verdict    = i_name_ch.final_byte && !root && err_all;
    end

    // per-name state, cleared after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_count  <= '0;
            r_label_count <= '0;
            r_error_seen  <= 1'b0;
        end else if (in_take) begin
            if (i_name_ch.final_byte) begin
                r_name_count  <= '0;
                r_label_count <= '0;
                r_error_seen  <= 1'b0;
            end else begin
                r_name_count  <= n_name_count;
                r_label_count <= n_label_count;
                r_error_seen  <= n_error_seen;
            end
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (o_res_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_lowered <= low;
            r_keep    <= n_keep;
            r_done    <= i_name_ch.final_byte;
            r_verdict <= n_verdict;
        end
    end

    assign o_res_ch.valid        = r_out_valid;
    assign o_res_ch.lowered_byte = r_lowered;
    assign o_res_ch.keep_byte    = r_keep;
    assign o_res_ch.name_done    = r_done;
    assign o_res_ch.verdict      = r_verdict;

    // checks
    `HC_ASSERT_NEXT(a_clear_after_last, in_take && i_name_ch.final_byte, r_name_count == '0 && r_error_seen == 1'b0, "state not cleared after last byte")
    `HC_ASSERT_IMPLY(a_verdict_on_done, r_out_valid && r_verdict, r_done, "verdict set on a byte that is not last")
    `HC_ASSERT_IMPLY(a_drop_on_done, r_out_valid && !r_keep, r_done, "byte dropped before end of name")
    `HC_ASSERT_ALWAYS(a_label_le_name, NAME_W'(r_label_count) <= r_name_count, "label count exceeds name count")

endmodule
